FILE: sv/fqu_pkg.sv
// ----------------------------------------------------------------------------
// fqu_pkg
// Shared sizes, command codes and result codes of the undo-capable queue.
// ----------------------------------------------------------------------------
package fqu_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int HISTORY_DEPTH = 32;
  localparam int ENTRY_BITS    = 16;

  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int HIDX_W = $clog2(HISTORY_DEPTH);
  localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int LEN_W  = 5;
  localparam int HREC_W = ENTRY_BITS + 1;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_LENGTH = 3'd3,
    CMD_UNDO   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NO_UNDO = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    UNDONE_NONE    = 2'd0,
    UNDONE_APPEND  = 2'd1,
    UNDONE_REMOVAL = 2'd2
  } undone_t;

  // history record kinds
  localparam logic KIND_APPEND  = 1'b0;
  localparam logic KIND_REMOVAL = 1'b1;

endpackage

FILE: sv/fqu_ram.sv
// ----------------------------------------------------------------------------
// fqu_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fqu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/fifo_queue_with_undo.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_undo
// Bounded FIFO of entry identifiers with an undo history of appends/removals.
//
//   channel  dir  tdata                          tuser
//   s_axis   in   [15:0] entry_id                [2:0] command
//   m_axis   out  [15:0] entry_out, [20:16] len  [1:0] status, [3:2] undone_kind
//
// A command is accepted in S_IDLE, which launches the queue and history RAM
// reads; S_EXEC does the read-modify-write and loads the result. S_EXEC holds
// while the previous result is still in the output register. Reset clears
// state, pointers, counters and m_axis_tvalid only; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module fifo_queue_with_undo
  import fqu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // entry_id
  input  logic [2:0]  s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // entry_out, length, zero pad
  output logic [3:0]  m_axis_tuser   // status, undone_kind
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                state;
  cmd_t                  cmd;
  logic [ENTRY_BITS-1:0] id;

  logic [QIDX_W-1:0] head_index, head_index_next;
  logic [QIDX_W-1:0] tail_index, tail_index_next;
  logic [QCNT_W-1:0] entry_count, entry_count_next;
  logic [HIDX_W-1:0] history_top, history_top_next;
  logic [HCNT_W-1:0] history_count, history_count_next;

  logic [QIDX_W-1:0]     head_prev, head_succ, tail_prev, tail_succ;
  logic [HIDX_W-1:0]     top_prev, top_succ;

  logic                  q_we;
  logic [QIDX_W-1:0]     q_waddr;
  logic [ENTRY_BITS-1:0] q_wdata, q_rdata;
  logic                  h_we;
  logic [HREC_W-1:0]     h_wdata, h_rdata;

  status_t               status_next;
  undone_t               undone_next;
  logic [ENTRY_BITS-1:0] entry_next;

  status_t               status_q;
  undone_t               undone_q;
  logic [ENTRY_BITS-1:0] entry_q;
  logic [LEN_W-1:0]      length_q;

  logic done;
  logic is_full, is_empty;

  assign s_axis_tready = (state == S_IDLE);
  assign done          = (state == S_EXEC) && (!m_axis_tvalid || m_axis_tready);
  assign is_full       = (entry_count >= QCNT_W'(QUEUE_DEPTH));
  assign is_empty      = (entry_count == '0);

  assign head_succ = (head_index == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_index + QIDX_W'(1);
  assign head_prev = (head_index == '0) ? QIDX_W'(QUEUE_DEPTH - 1) : head_index - QIDX_W'(1);
  assign tail_succ = (tail_index == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_index + QIDX_W'(1);
  assign tail_prev = (tail_index == '0) ? QIDX_W'(QUEUE_DEPTH - 1) : tail_index - QIDX_W'(1);
  assign top_succ  = (history_top == HIDX_W'(HISTORY_DEPTH - 1)) ? '0
                   : history_top + HIDX_W'(1);
  assign top_prev  = (history_top == '0) ? HIDX_W'(HISTORY_DEPTH - 1)
                   : history_top - HIDX_W'(1);

  fqu_ram #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_index),
    .rdata (q_rdata)
  );

  fqu_ram #(.WIDTH(HREC_W), .DEPTH(HISTORY_DEPTH)) u_history_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (history_top),
    .wdata (h_wdata),
    .raddr (top_prev),
    .rdata (h_rdata)
  );

  always_comb begin
    head_index_next    = head_index;
    tail_index_next    = tail_index;
    entry_count_next   = entry_count;
    history_top_next   = history_top;
    history_count_next = history_count;
    status_next        = ST_OK;
    undone_next        = UNDONE_NONE;
    entry_next         = '0;
    q_we               = 1'b0;
    q_waddr            = tail_index;
    q_wdata            = id;
    h_we               = 1'b0;
    h_wdata            = {KIND_APPEND, id};
    case (cmd)
      CMD_APPEND: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          q_we             = 1'b1;
          tail_index_next  = tail_succ;
          entry_count_next = entry_count + QCNT_W'(1);
          h_we             = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          entry_next       = q_rdata;
          head_index_next  = head_succ;
          entry_count_next = entry_count - QCNT_W'(1);
          h_we             = 1'b1;
          h_wdata          = {KIND_REMOVAL, q_rdata};
        end
      end
      CMD_PEEK: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          entry_next = q_rdata;
        end
      end
      CMD_LENGTH: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end
      end
      CMD_UNDO: begin
        if (history_count == '0) begin
          status_next = ST_NO_UNDO;
        end else begin
          history_top_next   = top_prev;
          history_count_next = history_count - HCNT_W'(1);
          if (h_rdata[HREC_W-1] == KIND_APPEND) begin
            if (is_empty) begin
              status_next = ST_EMPTY;
            end else begin
              tail_index_next  = tail_prev;
              entry_count_next = entry_count - QCNT_W'(1);
              entry_next       = h_rdata[ENTRY_BITS-1:0];
              undone_next      = UNDONE_APPEND;
            end
          end else begin
            if (is_full) begin
              status_next = ST_FULL;
            end else begin
              q_we             = 1'b1;
              q_waddr          = head_prev;
              q_wdata          = h_rdata[ENTRY_BITS-1:0];
              head_index_next  = head_prev;
              entry_count_next = entry_count + QCNT_W'(1);
              entry_next       = h_rdata[ENTRY_BITS-1:0];
              undone_next      = UNDONE_REMOVAL;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (h_we) begin
      history_top_next = top_succ;
      if (history_count < HCNT_W'(HISTORY_DEPTH)) begin
        history_count_next = history_count + HCNT_W'(1);
      end
    end
    if (!done) begin
      q_we = 1'b0;
      h_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head_index    <= '0;
      tail_index    <= '0;
      entry_count   <= '0;
      history_top   <= '0;
      history_count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (done) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd   <= cmd_t'(s_axis_tuser);
            id    <= s_axis_tdata;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (done) begin
            head_index    <= head_index_next;
            tail_index    <= tail_index_next;
            entry_count   <= entry_count_next;
            history_top   <= history_top_next;
            history_count <= history_count_next;
            status_q      <= status_next;
            undone_q      <= undone_next;
            entry_q       <= entry_next;
            length_q      <= LEN_W'(entry_count_next);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {3'b000, length_q, entry_q};
  assign m_axis_tuser = {undone_q, status_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_hist_bound: assert property (@(posedge clk) disable iff (rst)
    history_count <= HCNT_W'(HISTORY_DEPTH))
    else $error("history count exceeds depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0) |-> (head_index == tail_index))
    else $error("empty queue with head and tail apart");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_EXEC))
    else $error("result raised outside execute cycle");
`endif

endmodule
